### rtl/core/s9p_pkg.sv
// shared constants, types and helpers of the simple-9 word packer
package s9p_pkg;

  localparam int SLOTS   = 28;
  localparam int NSEL    = 9;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SEL_W   = 4;
  localparam int VAL_W   = 28;
  localparam int WORD_W  = 32;
  localparam int QDEPTH  = 2;
  localparam int Q_AW    = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] SEL_CNT [NSEL] =
    '{5'd28, 5'd14, 5'd9, 5'd7, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
  localparam logic [CNT_W-1:0] SEL_BITS [NSEL] =
    '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd9, 5'd14, 5'd28};

  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NSEL - 1);

  // one classified input beat
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SEL_W-1:0] cls;
    logic             wide;
    logic             eob;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } status_t;

  // lowest selector whose width holds the value
  function automatic logic [SEL_W-1:0] sel_class(input logic [VAL_W-1:0] v);
    logic [SEL_W-1:0] c;
    c = SEL_LAST;
    for (int k = NSEL - 1; k >= 0; k--) begin
      if ((v >> SEL_BITS[k]) == '0) c = SEL_W'(k);
    end
    return c;
  endfunction

endpackage

### rtl/core/simple9_word_packer.sv
// top level of the simple-9 word packer
//
// slave stream: one 32-bit value per beat, tlast asks for a flush of all
// buffered values after this one. master stream: one 32-bit simple-9 word
// per beat, tuser flags a value of 29 bits or more that was dropped (word
// zero), tlast marks the final word caused by one input beat.
// values are buffered up to 28; a full buffer packs one word, a flush packs
// words until the buffer is empty. an input beat that causes no word is
// handled in the idle state, so values stream in at one per cycle
// between words. each packed word then passes a selector search state and
// a word build and buffer shift state; the build waits while the output
// register is held. a dropped-value beat passes an error state for its
// error beat, which also waits on the output register.
// a two-entry command queue decouples input from the engine; the output
// register holds a word while the receiver stalls, and the engine waits on
// it while the queue keeps taking beats until full.
// reset empties the buffer, the queue and the output register.
module simple9_word_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic        s_axis_tlast_i,   // end_of_block
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // packed_word[31:0]
  output logic        m_axis_tuser_o,   // value_too_wide
  output logic        m_axis_tlast_o    // last_of_run
);
  import s9p_pkg::*;

  logic    q_full, q_push, q_empty, q_pop;
  cmd_t    push_cmd, pop_cmd;
  status_t status;

  s9p_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  s9p_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (pop_cmd)
  );

  s9p_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (pop_cmd),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .status_o        (status)
  );

`ifndef SYNTH
  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("dropped-value beat carries a nonzero word");

  a_selector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[31:28] <= SEL_LAST)
    else $error("packed word has an invalid selector");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.count <= CNT_W'(SLOTS))
    else $error("pending count beyond buffer size");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> status.count < CNT_W'(SLOTS))
    else $error("full buffer left unpacked");
`endif

endmodule

### rtl/core/s9p_front.sv
// input side: accepts beats and classifies each value by width
module s9p_front (
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [31:0]             s_axis_tdata_i,  // value[31:0]
  input  logic                    s_axis_tlast_i,  // end_of_block
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output s9p_pkg::cmd_t           q_cmd_o
);
  import s9p_pkg::*;

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_cmd_o.value = s_axis_tdata_i[VAL_W-1:0];
    q_cmd_o.wide  = |s_axis_tdata_i[WORD_W-1:VAL_W];
    q_cmd_o.eob   = s_axis_tlast_i;
    q_cmd_o.cls   = sel_class(s_axis_tdata_i[VAL_W-1:0]);
  end

endmodule

### rtl/core/s9p_queue.sv
// short command queue between the front and the packing engine
module s9p_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  s9p_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output s9p_pkg::cmd_t cmd_o
);
  import s9p_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [Q_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

### rtl/core/s9p_back.sv
// packing engine: pending buffer, selector search, word build, output register
module s9p_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  s9p_pkg::cmd_t        q_cmd_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,  // packed_word[31:0]
  output logic                 m_axis_tuser_o,  // value_too_wide
  output logic                 m_axis_tlast_o,  // last_of_run
  output s9p_pkg::status_t     status_o
);
  import s9p_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_SEL,
    S_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               flush_q, flush_d;
  logic [SEL_W-1:0]   sel_q, sel_d;
  logic [CNT_W-1:0]   taken_q, taken_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_wide_q, out_wide_d;
  logic               out_last_q, out_last_d;

  logic [VAL_W-1:0]   vals_q [SLOTS];
  logic [SEL_W-1:0]   cls_q  [SLOTS];
  logic [VAL_W-1:0]   sh_vals [SLOTS];
  logic [SEL_W-1:0]   sh_cls  [SLOTS];

  logic [NSEL-1:0]    bad;
  logic [SEL_W-1:0]   sel_pick;
  logic [CNT_W-1:0]   taken_pick;
  logic [WORD_W-1:0]  word;
  logic [CNT_W-1:0]   remain;
  logic               out_free;
  logic               append;
  logic               shift_en;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign append   = q_pop_o && !q_cmd_i.wide;
  assign shift_en = (state_q == S_EMIT) && out_free;
  assign remain   = count_q - taken_q;

  // selector search over the leading pending values
  always_comb begin
    for (int s = 0; s < NSEL; s++) begin
      bad[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (i < int'(SEL_CNT[s]) && CNT_W'(i) < count_q && cls_q[i] > SEL_W'(s)) begin
          bad[s] = 1'b1;
        end
      end
    end
    sel_pick = SEL_LAST;
    for (int s = NSEL - 1; s >= 0; s--) begin
      if (!bad[s]) sel_pick = SEL_W'(s);
    end
    taken_pick = count_q;
    for (int s = 0; s < NSEL; s++) begin
      if (sel_pick == SEL_W'(s) && SEL_CNT[s] < count_q) taken_pick = SEL_CNT[s];
    end
  end

  // word build for the chosen selector
  always_comb begin
    word = {sel_q, {VAL_W{1'b0}}};
    for (int s = 0; s < NSEL; s++) begin
      if (sel_q == SEL_W'(s)) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (i < int'(SEL_CNT[s]) && CNT_W'(i) < count_q) begin
            word[VAL_W-1:0] = word[VAL_W-1:0]
                            | (vals_q[i] << (VAL_W - int'(SEL_BITS[s]) * (i + 1)));
          end
        end
      end
    end
  end

  // drop the packed values from the head of the buffer
  always_comb begin
    int j;
    for (int i = 0; i < SLOTS; i++) begin
      sh_vals[i] = vals_q[i];
      sh_cls[i]  = cls_q[i];
      for (int s = 0; s < NSEL; s++) begin
        j = i + int'(SEL_CNT[s]);
        if (sel_q == SEL_W'(s)) begin
          if (j < SLOTS) begin
            sh_vals[i] = vals_q[j[SLOT_AW-1:0]];
            sh_cls[i]  = cls_q[j[SLOT_AW-1:0]];
          end
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    flush_d     = flush_q;
    sel_d       = sel_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_word_d  = out_word_q;
    out_wide_d  = out_wide_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          flush_d = q_cmd_i.eob;
          if (q_cmd_i.wide) begin
            state_d = S_ERR;
          end else begin
            count_d = count_q + CNT_W'(1);
            if (count_q == CNT_W'(SLOTS - 1) || q_cmd_i.eob) state_d = S_SEL;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '0;
          out_wide_d  = 1'b1;
          out_last_d  = !(flush_q && count_q != '0);
          state_d     = (flush_q && count_q != '0) ? S_SEL : S_IDLE;
        end
      end
      S_SEL: begin
        sel_d   = sel_pick;
        taken_d = taken_pick;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = word;
          out_wide_d  = 1'b0;
          out_last_d  = !(flush_q && remain != '0);
          count_d     = remain;
          state_d     = (flush_q && remain != '0) ? S_SEL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flush_q     <= 1'b0;
      sel_q       <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_wide_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flush_q     <= flush_d;
      sel_q       <= sel_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      out_wide_q  <= out_wide_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      vals_q[count_q[SLOT_AW-1:0]] <= q_cmd_i.value;
      cls_q[count_q[SLOT_AW-1:0]]  <= q_cmd_i.cls;
    end else if (shift_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        vals_q[i] <= sh_vals[i];
        cls_q[i]  <= sh_cls[i];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_wide_q;
  assign m_axis_tlast_o  = out_last_q;

  assign status_o.count = count_q;
  assign status_o.busy  = (state_q != S_IDLE);

endmodule

### sim/s9p_word_checker.sv
// checker for the simple-9 word packer: predicts output words from input beats and compares
module s9p_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,    // value[31:0]
  input  logic        in_last_i,    // end_of_block
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,   // packed_word[31:0]
  input  logic        out_user_i,   // value_too_wide
  input  logic        out_last_i,   // last_of_run
  output int          fail_count_o,
  output int          words_due_o
);
  import s9p_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              wide;
    logic              last;
  } s9_result_t;

  logic [VAL_W-1:0] held_vals [SLOTS];
  int               held_cnt = 0;
  int               failures = 0;
  s9_result_t       words_due_q [$];

  function automatic int sel_count(input int sel);
    case (sel)
      0: return 28;
      1: return 14;
      2: return 9;
      3: return 7;
      4: return 5;
      5: return 4;
      6: return 3;
      7: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic int sel_width(input int sel);
    case (sel)
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 5;
      5: return 7;
      6: return 9;
      7: return 14;
      default: return 28;
    endcase
  endfunction

  // first selector whose width holds all leading values, then drop them
  function automatic logic [WORD_W-1:0] pack_next_word();
    int               sel;
    int               take;
    int               w;
    bit               fits;
    logic [WORD_W-1:0] word;
    take = 0;
    w = VAL_W;
    for (sel = 0; sel < NSEL; sel++) begin
      take = (sel_count(sel) < held_cnt) ? sel_count(sel) : held_cnt;
      w = sel_width(sel);
      fits = 1'b1;
      for (int i = 0; i < take; i++) begin
        if ((held_vals[i] >> w) != '0) fits = 1'b0;
      end
      if (fits) break;
    end
    word = WORD_W'(sel) << VAL_W;
    for (int i = 0; i < take; i++) begin
      word = word | (WORD_W'(held_vals[i]) << (VAL_W - w * (i + 1)));
    end
    for (int i = 0; i < held_cnt - take; i++) begin
      held_vals[i] = held_vals[i + take];
    end
    held_cnt = held_cnt - take;
    return word;
  endfunction

  function automatic void predict_words(input logic [31:0] value, input logic eob);
    s9_result_t staged;
    bit         have_staged;
    int         n_res;
    have_staged = 1'b0;
    n_res = 0;
    staged = '0;
    if (value[31:VAL_W] != '0) begin
      staged = '{word: '0, wide: 1'b1, last: 1'b0};
      have_staged = 1'b1;
      n_res++;
    end else begin
      held_vals[held_cnt] = value[VAL_W-1:0];
      held_cnt++;
      if (held_cnt == SLOTS) begin
        staged = '{word: pack_next_word(), wide: 1'b0, last: 1'b0};
        have_staged = 1'b1;
        n_res++;
      end
    end
    if (eob) begin
      while (held_cnt > 0 && n_res < SLOTS) begin
        if (have_staged) words_due_q = {words_due_q, staged};
        staged = '{word: pack_next_word(), wide: 1'b0, last: 1'b0};
        have_staged = 1'b1;
        n_res++;
      end
    end
    if (have_staged) begin
      staged.last = 1'b1;
      words_due_q = {words_due_q, staged};
    end
  endfunction

  always @(posedge clk_i) begin
    s9_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (words_due_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected output beat: word %h wide %b last %b",
                     out_data_i, out_user_i, out_last_i);
        end else begin
          want = words_due_q.pop_front();
          if (out_data_i !== want.word || out_user_i !== want.wide ||
              out_last_i !== want.last) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: want word %h wide %b last %b, got word %h wide %b last %b",
                       want.word, want.wide, want.last,
                       out_data_i, out_user_i, out_last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_words(in_data_i, in_last_i);
      fail_count_o <= failures;
      words_due_o  <= words_due_q.size();
    end
  end

endmodule

### sim/tb_simple9_word_packer.sv
// testbench top for the simple-9 word packer: stimulus, receiver stalls and verdict
module tb_simple9_word_packer;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RAND_ITEMS   = 385;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_STALLS, RX_SPARSE} rx_mode_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic        m_user;
  logic        m_last;
  int          fail_count;
  int          words_due;
  int          burst_left = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  simple9_word_packer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  s9p_word_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_last_i    (s_last),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .out_last_i   (m_last),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  function automatic int class_width(input int idx);
    case (idx)
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 5;
      5: return 7;
      6: return 9;
      7: return 14;
      default: return 28;
    endcase
  endfunction

  function automatic logic [31:0] wide_value();
    logic [31:0] v;
    v = $urandom;
    v[28 + $urandom_range(0, 3)] = 1'b1;
    return v;
  endfunction

  // sender bursts with random gaps between them
  task automatic send_beat(input logic [31:0] value, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= eob;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic wait_words_done();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
  endtask

  initial begin
    int          blk_len;
    int          blk_width;
    bit          mixed;
    bit          flush;
    int          w;
    int          sent;
    logic [31:0] v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one value per selector width, each flushed alone
    for (int k = 0; k < 9; k++) send_beat((32'd1 << class_width(k)) - 1, 1'b1);
    send_beat(32'd0, 1'b1);
    // dropped values with an empty buffer, before a flush, and while values wait
    send_beat(32'h1000_0000, 1'b0);
    send_beat(32'd5, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat(32'h0800_0000, 1'b0);
    send_beat(32'hF000_0000, 1'b0);
    send_beat(32'd6, 1'b1);
    wait_words_done();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      blk_len = $urandom_range(0, 9);
      if (blk_len < 6) blk_len = $urandom_range(1, 20);
      else if (blk_len < 9) blk_len = $urandom_range(21, 60);
      else blk_len = $urandom_range(61, 90);
      blk_width = class_width($urandom_range(0, 8));
      mixed = ($urandom_range(0, 3) == 0);
      flush = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < blk_len; i++) begin
        w = mixed ? class_width($urandom_range(0, 8)) : blk_width;
        if ($urandom_range(0, 39) == 0) v = wide_value();
        else if ($urandom_range(0, 7) == 0) v = (32'd1 << w) - 1;
        else v = $urandom & ((32'd1 << w) - 1);
        send_beat(v, flush && (i == blk_len - 1));
        sent++;
      end
      if (sent >= RAND_ITEMS / 2 && sent - blk_len < RAND_ITEMS / 2) wait_words_done();
    end

    wait_words_done();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && words_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver stalls on its own changing pattern
  initial begin
    rx_mode_e mode;
    int       phase_left;
    int       stall;
    mode = RX_OPEN;
    phase_left = 0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      case (mode)
        RX_OPEN: m_ready <= 1'b1;
        RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
        RX_STALLS: begin
          if (stall > 0) begin
            m_ready <= 1'b0;
            stall--;
          end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall = $urandom_range(1, 12);
          end
        end
        default: m_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
